// ----- hdl/swhsr_pkg.sv -----
// Package for the single-wire humidity sensor reader.
// Holds the frame and timer sizes, register reset values, register indexes,
// status codes and the one-hot phase type. It has no dependencies.
`timescale 1ns / 1ps

package swhsr_pkg;

  localparam int FRAME_BITS     = 40;
  localparam int TIMER_BITS_DEF = 20;

  localparam int WAKE_W      = 16;
  localparam int TIMEOUT_W   = 20;
  localparam int THRESH_W    = 8;
  localparam int PULSE_W     = 8;
  localparam int BITCNT_W    = 6;
  localparam int STATUS_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [WAKE_W-1:0]    WAKE_RST    = 16'd18000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd1000000;
  localparam logic [THRESH_W-1:0]  THRESH_RST  = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAKE_LOW  = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_TIMEOUT  = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_WAKE      = 7'b0000010,
    PH_WAIT_LOW  = 7'b0000100,
    PH_WAIT_HIGH = 7'b0001000,
    PH_PREAMBLE  = 7'b0010000,
    PH_BIT_LOW   = 7'b0100000,
    PH_BIT_HIGH  = 7'b1000000
  } phase_e;

endpackage

// ----- hdl/single_wire_humidity_sensor_reader.sv -----
// Top level of the single-wire humidity sensor reader.
// Depends on swhsr_pkg for sizes, register indexes, status codes and phases.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+-------------------------------
//   in       | input     | in_valid_i / in_stall_o | start_req_i, line_level_i
//   out      | output    | out_valid_o/out_stall_i | drive_low_o .. temperature_fraction_o
//   cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each tick item updates the protocol state at the transfer edge, and its
// result is held in the output register.
// A new tick is taken every cycle while the output register is empty or drains.
// The input stalls only while a result waits and the output is stalled.
// Reset returns the reader to idle with the register reset values.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader #(
  parameter int TIMER_BITS = swhsr_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              start_req_i,
  input  logic                              line_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              drive_low_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [swhsr_pkg::STATUS_W-1:0]    status_o,
  output logic [swhsr_pkg::BYTE_W-1:0]      humidity_whole_o,
  output logic [swhsr_pkg::BYTE_W-1:0]      humidity_fraction_o,
  output logic [swhsr_pkg::BYTE_W-1:0]      temperature_whole_o,
  output logic [swhsr_pkg::BYTE_W-1:0]      temperature_fraction_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swhsr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import swhsr_pkg::*;

  localparam int CMP_W = (TIMER_BITS + 1 > TIMEOUT_W) ? TIMER_BITS + 1 : TIMEOUT_W;

  logic [WAKE_W-1:0]     wake_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [THRESH_W-1:0]   thresh_q;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic [PULSE_W-1:0]    pulse_q, pulse_d;
  logic [BITCNT_W-1:0]   bitcnt_q, bitcnt_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [STATUS_W-1:0]   status_q, status_d;

  logic                  done_d;
  logic                  data_valid_d;
  logic [TIMER_BITS:0]   elapsed;
  logic [BYTE_W-1:0]     sum;
  logic                  rx_bit;

  logic                  out_valid_q;
  logic                  drive_q, busy_q, done_q;
  logic [STATUS_W-1:0]   stat_q;
  logic [BYTE_W-1:0]     hw_q, hf_q, tw_q, tf_q;

  logic                  in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_q    <= WAKE_RST;
      timeout_q <= TIMEOUT_RST;
      thresh_q  <= THRESH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WAKE_LOW:  wake_q    <= cfg_data_i[WAKE_W-1:0];
        CFG_TIMEOUT:   timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_THRESHOLD: thresh_q  <= cfg_data_i[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign elapsed = {1'b0, tick_q} + 1'b1;
  assign rx_bit  = (pulse_q > thresh_q);
  assign sum     = frame_d[39:32] + frame_d[31:24] + frame_d[23:16] + frame_d[15:8];

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    pulse_d      = pulse_q;
    bitcnt_d     = bitcnt_q;
    frame_d      = frame_q;
    status_d     = status_q;
    done_d       = 1'b0;
    data_valid_d = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          frame_d  = '0;
          bitcnt_d = '0;
          pulse_d  = '0;
          if (wake_q == '0) begin
            phase_d = PH_WAIT_LOW;
            tick_d  = '0;
          end else begin
            phase_d = PH_WAKE;
            tick_d  = TIMER_BITS'(1);
          end
        end
      end
      PH_WAKE: begin
        if (CMP_W'(tick_q) >= CMP_W'(wake_q)) begin
          phase_d = PH_WAIT_LOW;
          tick_d  = '0;
        end else begin
          tick_d = TIMER_BITS'(tick_q + 1'b1);
        end
      end
      PH_WAIT_LOW, PH_WAIT_HIGH: begin
        if ((phase_q == PH_WAIT_LOW) ? !line_level_i : line_level_i) begin
          phase_d = (phase_q == PH_WAIT_LOW) ? PH_WAIT_HIGH : PH_PREAMBLE;
          tick_d  = '0;
        end else if (CMP_W'(elapsed) > CMP_W'(timeout_q)) begin
          phase_d  = PH_IDLE;
          tick_d   = '0;
          status_d = STATUS_TIMEOUT;
          done_d   = 1'b1;
        end else begin
          tick_d = elapsed[TIMER_BITS] ? '1 : elapsed[TIMER_BITS-1:0];
        end
      end
      PH_PREAMBLE: begin
        if (!line_level_i) begin
          phase_d = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        if (line_level_i) begin
          phase_d = PH_BIT_HIGH;
          pulse_d = PULSE_W'(1);
        end
      end
      PH_BIT_HIGH: begin
        if (line_level_i) begin
          if (pulse_q != '1) begin
            pulse_d = pulse_q + 1'b1;
          end
        end else begin
          frame_d  = {frame_q[FRAME_BITS-2:0], rx_bit};
          bitcnt_d = bitcnt_q + 1'b1;
          pulse_d  = '0;
          if (bitcnt_d >= BITCNT_W'(FRAME_BITS)) begin
            status_d     = (sum == frame_d[7:0]) ? STATUS_OK : STATUS_CHECKSUM;
            phase_d      = PH_IDLE;
            tick_d       = '0;
            done_d       = 1'b1;
            data_valid_d = 1'b1;
          end else begin
            phase_d = PH_BIT_LOW;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      pulse_q  <= '0;
      bitcnt_q <= '0;
      frame_q  <= '0;
      status_q <= STATUS_OK;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      pulse_q  <= pulse_d;
      bitcnt_q <= bitcnt_d;
      frame_q  <= frame_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      drive_q <= (phase_d == PH_WAKE);
      busy_q  <= (phase_d != PH_IDLE);
      done_q  <= done_d;
      stat_q  <= status_d;
      hw_q    <= data_valid_d ? frame_d[39:32] : '0;
      hf_q    <= data_valid_d ? frame_d[31:24] : '0;
      tw_q    <= data_valid_d ? frame_d[23:16] : '0;
      tf_q    <= data_valid_d ? frame_d[15:8]  : '0;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign drive_low_o            = drive_q;
  assign busy_res_o             = busy_q;
  assign done_res_o             = done_q;
  assign status_o               = stat_q;
  assign humidity_whole_o       = hw_q;
  assign humidity_fraction_o    = hf_q;
  assign temperature_whole_o    = tw_q;
  assign temperature_fraction_o = tf_q;

endmodule

// ----- hdl/swhsr_checker.sv -----
// Port-level checker for the single-wire humidity sensor reader.
// Depends on swhsr_pkg for status codes and is bound to the top level below.
`timescale 1ns / 1ps

module swhsr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             drive_low_o,
  input logic                             busy_res_o,
  input logic                             done_res_o,
  input logic [swhsr_pkg::STATUS_W-1:0]   status_o,
  input logic [swhsr_pkg::BYTE_W-1:0]     humidity_whole_o,
  input logic [swhsr_pkg::BYTE_W-1:0]     humidity_fraction_o,
  input logic [swhsr_pkg::BYTE_W-1:0]     temperature_whole_o,
  input logic [swhsr_pkg::BYTE_W-1:0]     temperature_fraction_o
);
  import swhsr_pkg::*;

  logic data_nonzero;

  assign data_nonzero = (humidity_whole_o != '0) || (humidity_fraction_o != '0) ||
                        (temperature_whole_o != '0) || (temperature_fraction_o != '0);

  // A finished reading is never reported as still in progress.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done result reported while busy");

  // The line is only pulled low during a reading.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o && !done_res_o)
    else $error("line driven low outside a reading");

  // Data bytes appear only on a completed frame, never with a timeout.
  a_data_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_nonzero |-> done_res_o && (status_o != STATUS_TIMEOUT))
    else $error("data bytes outside a completed frame");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(done_res_o) && $stable(busy_res_o))
    else $error("stalled result changed");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (.*);
